[hw/rtl/crsf_pkg.sv]
// Shared constants and types for the CRSF RC frame receiver.
package crsf_pkg;

   // Request kinds
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_CRC_ERR   = 2'd1;
   localparam logic [1:0] ST_LINK_DOWN = 2'd2;

   // Framing constants
   localparam logic [7:0] SYNC_BYTE      = 8'hC8;
   localparam logic [7:0] RC_TYPE        = 8'h16;
   localparam int         RC_PAYLOAD_LEN = 22;
   localparam logic [7:0] RC_LEN_BYTE    = 8'(RC_PAYLOAD_LEN + 2);
   localparam logic [7:0] MIN_LEN        = 8'd4;
   localparam logic [7:0] CRC_POLY       = 8'hD5;
   localparam int         CH_BITS        = 11;
   localparam int         PAYLOAD_BITS   = RC_PAYLOAD_LEN * 8;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;

   // Control into the bit-serial CRC unit
   typedef struct packed {
      logic       clear;
      logic       start;
      logic [7:0] data;
   } crc_ctrl_type;

   // Control into the payload shift register
   typedef struct packed {
      logic       load;
      logic       advance;
      logic [7:0] data;
   } chan_ctrl_type;

endpackage

[hw/rtl/crsf_crc.sv]
// Bit-serial CRC-8 (poly 0xD5) unit, one shift step per cycle.
module crsf_crc (
   input  logic                   clock,
   input  logic                   reset,
   input  crsf_pkg::crc_ctrl_type ctrl,
   output logic [7:0]             crc,
   output logic                   busy
);

   logic [7:0] crc_ff, crc_in;
   logic [2:0] bit_ff, bit_in;
   logic       busy_ff, busy_in;

   // clear on sync, fold byte in on start, then eight shift steps
   always_comb begin
      crc_in  = crc_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (ctrl.clear) begin
         crc_in = '0;
      end else if (ctrl.start) begin
         crc_in  = crc_ff ^ ctrl.data;
         bit_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (crc_ff[7]) begin
            crc_in = {crc_ff[6:0], 1'b0} ^ crsf_pkg::CRC_POLY;
         end else begin
            crc_in = {crc_ff[6:0], 1'b0};
         end
         bit_in = bit_ff + 3'd1;
         if (bit_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= '0;
         bit_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         bit_ff  <= bit_in;
         busy_ff <= busy_in;
      end
   end

   assign crc  = crc_ff;
   assign busy = busy_ff;

endmodule

[hw/rtl/crsf_chan.sv]
// Payload shift register: bytes shift in, 11-bit channels shift out.
module crsf_chan (
   input  logic                    clock,
   input  crsf_pkg::chan_ctrl_type ctrl,
   output logic [10:0]             value
);

   localparam int PB = crsf_pkg::PAYLOAD_BITS;
   localparam int CB = crsf_pkg::CH_BITS;

   logic [PB-1:0] sr_ff, sr_in;

   // byte enters at the top so the first payload byte ends at the bottom
   always_comb begin
      sr_in = sr_ff;
      if (ctrl.load) begin
         sr_in = {ctrl.data, sr_ff[PB-1:8]};
      end else if (ctrl.advance) begin
         sr_in = {{CB{1'b0}}, sr_ff[PB-1:CB]};
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

   assign value = sr_ff[CB-1:0];

endmodule

[hw/rtl/crsf_rc_frame_receiver.sv]
// Top level of the CRSF RC frame receiver.
//
// Input requests carry either one received serial byte or a tick only, with
// the current millisecond time. The parser hunts for sync 0xC8, takes the
// length byte, checks the CRC-8 (poly 0xD5) over type and payload and
// decodes good RC-channel frames into one 11-bit channel per result.
// Every request gives exactly one result, except the final byte of a good RC
// frame, which gives NUM_CHANNELS results, one per cycle while rsp_tready is
// high, the last one with rsp_tlast set. The first result shows in the cycle
// after its request is taken. A byte that enters the CRC keeps the bit-serial
// CRC unit busy, and the next request is taken once that unit is free and
// all results of the previous request have been taken. While the receiver
// holds rsp_tready low the result stays registered and no request is taken.
// Reset (synchronous) clears the parser, CRC, link state and the timeout
// register to 500 ms; no clearing pass is needed.
module crsf_rc_frame_receiver #(
   parameter int MAX_FRAME_LEN = 64,
   parameter int NUM_CHANNELS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // rx_byte[7:0], now_ms[39:8]
   input  logic        req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // link_up[0], channel_valid[1],
                                    // channel_index[5:2], channel_value[16:6]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int CW = $clog2(MAX_FRAME_LEN + 2);
   localparam int MW = (CW > 8) ? CW : 8;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EMIT = 1'b1;

   logic          st_ff, st_in;
   logic [CW-1:0] bc_ff, bc_in;
   logic [7:0]    el_ff, el_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    type_ff, type_in;
   logic [31:0]   last_ff, last_in;
   logic          link_ff, link_in;
   logic [15:0]   timeout_ff;
   logic [1:0]    ost_ff, ost_in;
   logic          rc_ff, rc_in;
   logic [3:0]    idx_ff, idx_in;

   logic          req_acc, rsp_acc, is_byte, out_last;
   logic [7:0]    rx_byte, new_el;
   logic [31:0]   now_ms, elapsed;
   logic          timed_out, rc_good, crc_err;
   logic [MW-1:0] pos_w, el_w;
   logic [7:0]    crc_val;
   logic          crc_busy;
   logic [10:0]   chan_value;

   crsf_pkg::crc_ctrl_type  crc_ctrl;
   crsf_pkg::chan_ctrl_type chan_ctrl;

   assign rx_byte = req_tdata[7:0];
   assign now_ms  = req_tdata[39:8];
   assign req_tready = (st_ff == S_IDLE) && !crc_busy;
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign is_byte = req_acc && (req_tuser == crsf_pkg::REQ_BYTE);
   assign new_el  = rx_byte + 8'd2;
   assign pos_w   = MW'(bc_ff);
   assign el_w    = MW'(el_ff);
   assign out_last = !rc_ff || (idx_ff == 4'(NUM_CHANNELS - 1));

   // frame parser
   always_comb begin
      bc_in    = bc_ff;
      el_in    = el_ff;
      len_in   = len_ff;
      type_in  = type_ff;
      crc_ctrl = '0;
      crc_ctrl.data = rx_byte;
      chan_ctrl = '0;
      chan_ctrl.data = rx_byte;
      chan_ctrl.advance = rsp_acc && rc_ff;
      rc_good  = 1'b0;
      crc_err  = 1'b0;
      if (is_byte) begin
         if (bc_ff == '0) begin
            if (rx_byte == crsf_pkg::SYNC_BYTE) begin
               bc_in = CW'(1);
               crc_ctrl.clear = 1'b1;
            end
         end else if (pos_w <= MW'(MAX_FRAME_LEN)) begin
            bc_in = bc_ff + CW'(1);
            if (bc_ff == CW'(1)) begin
               len_in = rx_byte;
               el_in  = new_el;
               if (MW'(new_el) > MW'(MAX_FRAME_LEN) || new_el < crsf_pkg::MIN_LEN) begin
                  bc_in = '0;
                  el_in = '0;
               end
            end else if (el_ff != '0) begin
               if (bc_ff == CW'(2)) begin
                  type_in = rx_byte;
               end
               // type and payload bytes go through the CRC
               if (pos_w < el_w - MW'(1)) begin
                  crc_ctrl.start = 1'b1;
                  if (pos_w >= MW'(3)) begin
                     chan_ctrl.load = 1'b1;
                  end
               end
               // final byte holds the CRC
               if (pos_w + MW'(1) >= el_w) begin
                  if (crc_val == rx_byte) begin
                     if (type_ff == crsf_pkg::RC_TYPE && len_ff == crsf_pkg::RC_LEN_BYTE) begin
                        rc_good = 1'b1;
                     end
                  end else begin
                     crc_err = 1'b1;
                  end
                  bc_in = '0;
                  el_in = '0;
               end
            end
         end else begin
            bc_in = '0;
            el_in = '0;
         end
      end
   end

   // link timeout
   assign elapsed   = now_ms - last_ff;
   assign timed_out = elapsed > {16'd0, timeout_ff};

   always_comb begin
      last_in = last_ff;
      link_in = link_ff;
      if (req_acc) begin
         if (rc_good) begin
            last_in = now_ms;
         end
         link_in = rc_good || (link_ff && !timed_out);
      end
   end

   // result sequencing
   always_comb begin
      st_in  = st_ff;
      ost_in = ost_ff;
      rc_in  = rc_ff;
      idx_in = idx_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (req_acc) begin
               st_in  = S_EMIT;
               rc_in  = rc_good;
               idx_in = '0;
               if (!link_in) begin
                  ost_in = crsf_pkg::ST_LINK_DOWN;
               end else if (crc_err) begin
                  ost_in = crsf_pkg::ST_CRC_ERR;
               end else begin
                  ost_in = crsf_pkg::ST_OK;
               end
            end
         end
         S_EMIT: begin
            if (rsp_acc) begin
               if (out_last) begin
                  st_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_IDLE;
         bc_ff      <= '0;
         el_ff      <= '0;
         last_ff    <= '0;
         link_ff    <= 1'b0;
         timeout_ff <= crsf_pkg::TIMEOUT_RESET;
         rc_ff      <= 1'b0;
         idx_ff     <= '0;
      end else begin
         st_ff   <= st_in;
         bc_ff   <= bc_in;
         el_ff   <= el_in;
         last_ff <= last_in;
         link_ff <= link_in;
         rc_ff   <= rc_in;
         idx_ff  <= idx_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // payload-side registers
   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      type_ff <= type_in;
      ost_ff  <= ost_in;
   end

   crsf_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .crc   (crc_val),
      .busy  (crc_busy)
   );

   crsf_chan u_chan (
      .clock (clock),
      .ctrl  (chan_ctrl),
      .value (chan_value)
   );

   // result outputs
   assign rsp_tvalid = (st_ff == S_EMIT);
   assign rsp_tuser  = ost_ff;
   assign rsp_tlast  = out_last;
   assign rsp_tdata  = {7'd0,
                        rc_ff ? chan_value : 11'd0,
                        rc_ff ? idx_ff : 4'd0,
                        rc_ff,
                        link_ff};

endmodule

[hw/rtl/crsf_checker.sv]
// Port-level checker for the CRSF RC frame receiver, with its bind.
module crsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no request is taken while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while results pending");

   // a result without a channel ends its request
   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tlast)
      else $error("non-channel result not last");

   // channel results come only from a live link with status ok
   a_chan_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0] && rsp_tuser == crsf_pkg::ST_OK)
      else $error("channel result with bad status");

   // link down status matches the link flag
   a_down_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == crsf_pkg::ST_LINK_DOWN) == !rsp_tdata[0]))
      else $error("link status and flag disagree");

endmodule

bind crsf_rc_frame_receiver crsf_checker u_crsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[tb/crsf_rc_frame_receiver_tb.sv]
// Self-checking testbench for the CRSF RC frame receiver: directed and random byte streams.
module crsf_rc_frame_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAME_LEN = 64;
   localparam int NUM_CHANNELS  = 16;

   // One expected result, field by field
   typedef struct packed {
      logic [1:0]  status;
      logic        link_up;
      logic        chan_valid;
      logic [3:0]  chan_index;
      logic [10:0] chan_value;
      logic        last;
   } rc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // rx_byte[7:0], now_ms[39:8]
   logic        req_tuser = 1'b0;  // req_type[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;         // link_up[0], channel_valid[1],
                                   // channel_index[5:2], channel_value[16:6]
   logic [1:0]  rsp_tuser;         // status[1:0]
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   crsf_rc_frame_receiver #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Parser state mirrored by the predictor
   logic [7:0]  rx_frame [0:MAX_FRAME_LEN];
   int unsigned frame_count = 0;
   logic [7:0]  frame_len = '0;
   logic [7:0]  crc_acc = '0;
   logic [31:0] last_good_ms = '0;
   logic        link_state = 1'b0;
   logic [15:0] link_timeout = crsf_pkg::TIMEOUT_RESET;

   rc_result_type pending_results[$];

   // Stimulus state and run statistics
   logic [7:0]  frame_bytes[$];
   logic [31:0] sim_ms = '0;
   logic        idle_enable = 1'b1;
   int unsigned requests_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned frames_decoded = 0;
   int unsigned crc_errors_seen = 0;
   int unsigned link_down_seen = 0;
   int unsigned mismatches = 0;

   // CRC-8, polynomial 0xD5, MSB first
   function automatic logic [7:0] crc8_d5(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] c;
      c = crc_in ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ crsf_pkg::CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Advance the parser by one accepted request and queue its results
   function automatic void predict_request(input logic kind, input logic [7:0] b,
                                           input logic [31:0] now);
      logic          crc_bad;
      logic          rc_frame;
      int unsigned   pos;
      logic [1:0]    st;
      logic [175:0]  payload_bits;
      rc_result_type r;
      crc_bad  = 1'b0;
      rc_frame = 1'b0;
      if (kind == crsf_pkg::REQ_BYTE) begin
         if (frame_count == 0) begin
            if (b == crsf_pkg::SYNC_BYTE) begin
               rx_frame[0] = b;
               frame_count = 1;
               crc_acc = '0;
            end
         end else if (frame_count <= MAX_FRAME_LEN) begin
            pos = frame_count;
            rx_frame[pos] = b;
            frame_count = pos + 1;
            if (frame_count == 2) begin
               frame_len = b + 8'd2;
               if (frame_len > MAX_FRAME_LEN || frame_len < crsf_pkg::MIN_LEN) begin
                  frame_count = 0;
                  frame_len = '0;
               end
            end else if (frame_len != 0) begin
               if (pos < frame_len - 1) crc_acc = crc8_d5(crc_acc, b);
               if (frame_count >= frame_len) begin
                  if (crc_acc == rx_frame[frame_len - 1]) begin
                     if (rx_frame[2] == crsf_pkg::RC_TYPE &&
                         rx_frame[1] == crsf_pkg::RC_LEN_BYTE) begin
                        rc_frame = 1'b1;
                        last_good_ms = now;
                        link_state = 1'b1;
                     end
                  end else begin
                     crc_bad = 1'b1;
                  end
                  frame_count = 0;
                  frame_len = '0;
               end
            end
         end else begin
            frame_count = 0;
            frame_len = '0;
         end
      end

      // timeout check, elapsed time modulo 2^32
      if (link_state && (now - last_good_ms) > {16'd0, link_timeout}) link_state = 1'b0;

      st = !link_state ? crsf_pkg::ST_LINK_DOWN :
           (crc_bad ? crsf_pkg::ST_CRC_ERR : crsf_pkg::ST_OK);
      r.status     = st;
      r.link_up    = link_state;
      r.chan_valid = rc_frame;
      r.chan_index = '0;
      r.chan_value = '0;
      r.last       = 1'b1;
      if (rc_frame) begin
         for (int j = 0; j < crsf_pkg::RC_PAYLOAD_LEN; j++) begin
            payload_bits[j*8 +: 8] = rx_frame[3 + j];
         end
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            r.chan_index = 4'(k);
            r.chan_value = payload_bits[k*crsf_pkg::CH_BITS +: crsf_pkg::CH_BITS];
            r.last       = (k == NUM_CHANNELS - 1);
            pending_results.push_back(r);
         end
      end else begin
         pending_results.push_back(r);
      end
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // Predict on each accepted request, then check each accepted result
   always @(posedge clock) begin : track_frames
      rc_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata[7:0], req_tdata[39:8]);
            requests_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual status %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("link_up", 32'(want.link_up), 32'(rsp_tdata[0]));
               check_field("channel_valid", 32'(want.chan_valid), 32'(rsp_tdata[1]));
               check_field("channel_index", 32'(want.chan_index), 32'(rsp_tdata[5:2]));
               check_field("channel_value", 32'(want.chan_value), 32'(rsp_tdata[16:6]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
               results_checked++;
               if (want.chan_valid && want.last) frames_decoded++;
               if (want.status == crsf_pkg::ST_CRC_ERR) crc_errors_seen++;
               if (want.status == crsf_pkg::ST_LINK_DOWN) link_down_seen++;
            end
         end
      end
   end

   // Result-side back-pressure in random bursts
   initial begin : rsp_backpressure
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Send one request and wait for the handshake
   task automatic send_request(input logic kind, input logic [7:0] b, input logic [31:0] now);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {now, b};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_request(crsf_pkg::REQ_BYTE, b, sim_ms);
      sim_ms += $urandom_range(0, 1);
   endtask

   // Tick at an absolute time; the byte lane carries junk
   task automatic send_tick(input logic [31:0] now);
      sim_ms = now;
      send_request(crsf_pkg::REQ_TICK, 8'($urandom), sim_ms);
   endtask

   task automatic send_frame(input int n_bytes);
      for (int i = 0; i < n_bytes && i < frame_bytes.size(); i++) send_byte(frame_bytes[i]);
   endtask

   // Sender pauses until every queued result has been taken
   task automatic wait_for_all_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic set_link_timeout(input logic [15:0] value);
      wait_for_all_results();
      repeat (12) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      link_timeout = value;
   endtask

   // RC channel frame: sync, length 24, type, 22 payload bytes, CRC
   task automatic make_rc_frame(input logic [175:0] chans, input logic corrupt);
      logic [7:0] crc;
      frame_bytes.delete();
      frame_bytes.push_back(crsf_pkg::SYNC_BYTE);
      frame_bytes.push_back(crsf_pkg::RC_LEN_BYTE);
      frame_bytes.push_back(crsf_pkg::RC_TYPE);
      crc = crc8_d5(8'd0, crsf_pkg::RC_TYPE);
      for (int j = 0; j < crsf_pkg::RC_PAYLOAD_LEN; j++) begin
         frame_bytes.push_back(chans[j*8 +: 8]);
         crc = crc8_d5(crc, chans[j*8 +: 8]);
      end
      frame_bytes.push_back(corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc);
   endtask

   // Any frame: sync, length, type, length-2 random payload bytes, CRC
   task automatic make_other_frame(input logic [7:0] ftype, input logic [7:0] len_byte,
                                   input logic corrupt);
      logic [7:0] crc;
      logic [7:0] b;
      frame_bytes.delete();
      frame_bytes.push_back(crsf_pkg::SYNC_BYTE);
      frame_bytes.push_back(len_byte);
      frame_bytes.push_back(ftype);
      crc = crc8_d5(8'd0, ftype);
      for (int j = 0; j < int'(len_byte) - 2; j++) begin
         b = 8'($urandom);
         frame_bytes.push_back(b);
         crc = crc8_d5(crc, b);
      end
      frame_bytes.push_back(corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc);
   endtask

   function automatic logic [175:0] random_channels();
      logic [191:0] rnd;
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return rnd[175:0];
   endfunction

   // Mostly well-formed frames with random content, plus broken ones, noise and ticks
   task automatic run_random_traffic(input int n_items);
      int unsigned start_count;
      int unsigned pick;
      logic [7:0]  len_byte;
      start_count = requests_accepted;
      while (requests_accepted - start_count < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            make_rc_frame(random_channels(), 1'b0);
            send_frame(frame_bytes.size());
         end else if (pick < 48) begin
            make_rc_frame(random_channels(), 1'b1);
            send_frame(frame_bytes.size());
         end else if (pick < 62) begin
            // other frames, mostly short, now and then the longest allowed
            case ($urandom_range(0, 7))
               0: len_byte = 8'(MAX_FRAME_LEN - 2);
               1: len_byte = 8'($urandom_range(2, MAX_FRAME_LEN - 2));
               default: len_byte = 8'($urandom_range(2, 8));
            endcase
            make_other_frame(8'($urandom), len_byte, $urandom_range(0, 3) == 0);
            send_frame(frame_bytes.size());
         end else if (pick < 70) begin
            // RC frame cut short, later bytes get swallowed into it
            make_rc_frame(random_channels(), 1'b0);
            send_frame($urandom_range(1, 25));
         end else if (pick < 80) begin
            if ($urandom_range(0, 1) == 1) begin
               send_byte(crsf_pkg::SYNC_BYTE);
               send_byte(8'($urandom));
            end
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0: send_tick(sim_ms + $urandom_range(0, 50));
               1: send_tick(last_good_ms + {16'd0, link_timeout} + $urandom_range(0, 2) - 1);
               2: send_tick(sim_ms + $urandom_range(0, 70000));
               default: send_tick($urandom);
            endcase
         end
      end
   endtask

   // ---- Directed tests ----

   task automatic test_idle_link_down();
      send_tick(32'd0);
      send_tick(32'hFFFF_FFFF);
   endtask

   task automatic test_bad_lengths();
      // length byte gives 3, 65, 0 and 1 bytes: all dropped
      send_byte(crsf_pkg::SYNC_BYTE);
      send_byte(8'h01);
      send_byte(crsf_pkg::SYNC_BYTE);
      send_byte(8'(MAX_FRAME_LEN - 1));
      send_byte(crsf_pkg::SYNC_BYTE);
      send_byte(8'hFE);
      send_byte(crsf_pkg::SYNC_BYTE);
      send_byte(8'hFF);
   endtask

   task automatic test_rc_frame_extremes();
      logic [10:0]  vals [NUM_CHANNELS] = '{11'h000, 11'h7FF, 11'h555, 11'h2AA,
                                            11'h001, 11'h400, 11'h7FE, 11'h3FF,
                                            11'h123, 11'h6DB, 11'h000, 11'h7FF,
                                            11'h0F0, 11'h70F, 11'h2A5, 11'h5AA};
      logic [175:0] chans;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         chans[k*crsf_pkg::CH_BITS +: crsf_pkg::CH_BITS] = vals[k];
      end
      // start just below the time wrap
      sim_ms = 32'hFFFF_FF00;
      make_rc_frame(chans, 1'b0);
      send_frame(frame_bytes.size());
   endtask

   task automatic test_crc_error();
      wait_for_all_results();
      make_other_frame(crsf_pkg::RC_TYPE, 8'd2, 1'b1);
      send_frame(frame_bytes.size());
   endtask

   task automatic test_other_frame();
      // good CRC but not an RC frame: accepted silently
      make_other_frame(8'h21, 8'd4, 1'b0);
      send_frame(frame_bytes.size());
      make_other_frame(crsf_pkg::RC_TYPE, 8'd3, 1'b0);
      send_frame(frame_bytes.size());
   endtask

   task automatic test_timeout_boundary();
      // elapsed time equal to the timeout keeps the link, one more drops it
      send_tick(last_good_ms + {16'd0, link_timeout});
      send_tick(last_good_ms + {16'd0, link_timeout} + 32'd1);
   endtask

   task automatic test_default_timeout_traffic();
      run_random_traffic(60);
   endtask

   task automatic test_zero_timeout();
      set_link_timeout(16'h0000);
      make_rc_frame(random_channels(), 1'b0);
      send_frame(frame_bytes.size());
      // let the frame time settle in the predictor before aiming ticks at it
      wait_for_all_results();
      send_tick(last_good_ms);
      send_tick(last_good_ms + 32'd1);
      run_random_traffic(40);
   endtask

   task automatic test_max_timeout();
      set_link_timeout(16'hFFFF);
      run_random_traffic(60);
   endtask

   // final stretch: random timeout, no idling on either side
   task automatic test_random_timeout_full_rate();
      set_link_timeout(16'($urandom_range(1, 2000)));
      idle_enable = 1'b0;
      run_random_traffic(60);
   endtask

   initial begin : main
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_link_down();
      test_bad_lengths();
      test_rc_frame_extremes();
      test_crc_error();
      test_other_frame();
      test_timeout_boundary();
      test_default_timeout_traffic();
      test_zero_timeout();
      test_max_timeout();
      test_random_timeout_full_rate();

      wait_for_all_results();
      repeat (24) @(posedge clock);

      $display("Run covered %0d requests and %0d results: %0d RC frames decoded,",
               requests_accepted, results_checked, frames_decoded);
      $display("%0d CRC error results, %0d link-down results, timeouts 500, 0, max, random.",
               crc_errors_seen, link_down_seen);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/crsf_pkg.sv
hw/rtl/crsf_crc.sv
hw/rtl/crsf_chan.sv
hw/rtl/crsf_rc_frame_receiver.sv
hw/rtl/crsf_checker.sv
tb/crsf_rc_frame_receiver_tb.sv
